// ----- hdl/hsl2rgb_pkg.sv -----
// Shared types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

   localparam int CH_W    = 16;
   localparam int WIDE_W  = CH_W + 1;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [WIDE_W-1:0] ONE_Q16 = WIDE_W'(1) << CH_W;

   // Hue sector: which sixth of the color wheel the hue falls in.
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

   // Classified item passed from the front end to the arithmetic back end.
   typedef struct packed {
      logic              grey;
      sector_type        sector;
      logic [WIDE_W-1:0] span;
      logic [WIDE_W-1:0] weight;
      logic [CH_W-1:0]   saturation;
      logic [CH_W-1:0]   lightness;
   } class_type;

endpackage

// ----- hdl/hsl2rgb_front.sv -----
// Front end: accepts pixels and works out sector, hue weight and lightness span.
module hsl2rgb_front import hsl2rgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  logic [CH_W-1:0] hue,
   input  logic [CH_W-1:0] saturation,
   input  logic [CH_W-1:0] lightness,
   output logic            out_valid,
   input  logic            out_ready,
   output class_type       out_item
);

   logic              valid_ff;
   logic              valid_in;
   class_type         item_ff;
   class_type         item_in;
   logic [CH_W+2:0]   hue6;
   logic [WIDE_W-1:0] frac2;
   logic [WIDE_W-1:0] dist_h;
   logic [WIDE_W-1:0] two_l;
   logic [WIDE_W-1:0] dist_l;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      hue6   = ({3'b000, hue} << 2) + ({3'b000, hue} << 1);
      frac2  = hue6[WIDE_W-1:0];
      dist_h = (frac2 >= ONE_Q16) ? (frac2 - ONE_Q16) : (ONE_Q16 - frac2);
      two_l  = {lightness, 1'b0};
      dist_l = (two_l >= ONE_Q16) ? (two_l - ONE_Q16) : (ONE_Q16 - two_l);

      item_in.grey       = (saturation == '0);
      item_in.sector     = sector_type'(hue6[CH_W+2:CH_W]);
      item_in.span       = ONE_Q16 - dist_l;
      item_in.weight     = ONE_Q16 - dist_h;
      item_in.saturation = saturation;
      item_in.lightness  = lightness;

      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

// ----- hdl/hsl2rgb_queue.sv -----
// Short queue of classified items between the front end and the back end.
module hsl2rgb_queue import hsl2rgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  class_type in_item,
   output logic      out_valid,
   input  logic      out_ready,
   output class_type out_item
);

   class_type            slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff;
   logic [Q_CNT_W-1:0]   count_in;
   logic                 push;
   logic                 pop;

   assign in_ready  = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("queue count above depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == Q_CNT_W'(Q_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// ----- hdl/hsl2rgb_back.sv -----
// Back end: chroma and secondary products, offset, placement and clamp.
module hsl2rgb_back import hsl2rgb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  class_type         in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [CH_W-1:0]   red_out,
   output logic [CH_W-1:0]   green_out,
   output logic [CH_W-1:0]   blue_out
);

   // Stage one: chroma product.
   logic              s1_valid_ff;
   logic              s1_grey_ff;
   sector_type        s1_sector_ff;
   logic [WIDE_W-1:0] s1_weight_ff;
   logic [CH_W-1:0]   s1_light_ff;
   logic [CH_W-1:0]   s1_chroma_ff;
   logic [2*CH_W:0]   chroma_prod;

   // Stage two: secondary product and offset.
   logic                     s2_valid_ff;
   logic                     s2_grey_ff;
   sector_type               s2_sector_ff;
   logic [CH_W-1:0]          s2_light_ff;
   logic [CH_W-1:0]          s2_chroma_ff;
   logic [CH_W-1:0]          s2_x_ff;
   logic signed [CH_W:0]     s2_m_ff;
   logic [2*CH_W:0]          x_prod;
   logic signed [CH_W:0]     m_in;

   // Stage three: output register.
   logic              out_valid_ff;
   logic [CH_W-1:0]   red_ff;
   logic [CH_W-1:0]   green_ff;
   logic [CH_W-1:0]   blue_ff;
   logic [CH_W-1:0]   red_in;
   logic [CH_W-1:0]   green_in;
   logic [CH_W-1:0]   blue_in;
   logic [CH_W-1:0]   pr;
   logic [CH_W-1:0]   pg;
   logic [CH_W-1:0]   pb;

   logic adv3;
   logic adv2;
   logic adv1;

   assign adv3     = !out_valid_ff || out_ready;
   assign adv2     = !s2_valid_ff || adv3;
   assign adv1     = !s1_valid_ff || adv2;
   assign in_ready = adv1;

   assign out_valid = out_valid_ff;
   assign red_out   = red_ff;
   assign green_out = green_ff;
   assign blue_out  = blue_ff;

   assign chroma_prod = in_item.span * {1'b0, in_item.saturation};
   assign x_prod      = {1'b0, s1_chroma_ff} * s1_weight_ff;
   assign m_in        = $signed({1'b0, s1_light_ff}) - $signed({2'b00, s1_chroma_ff[CH_W-1:1]});

   function automatic logic [CH_W-1:0] clamp_sum(input logic [CH_W-1:0] placed,
                                                 input logic signed [CH_W:0] m);
      logic signed [CH_W+1:0] sum;
      begin
         sum = $signed({2'b00, placed}) + {m[CH_W], m};
         if (sum < 0) begin
            clamp_sum = '0;
         end else if (sum > $signed({2'b00, {CH_W{1'b1}}})) begin
            clamp_sum = '1;
         end else begin
            clamp_sum = sum[CH_W-1:0];
         end
      end
   endfunction

   always_comb begin
      pr = '0;
      pg = '0;
      pb = '0;
      unique case (s2_sector_ff)
         SEC_RED_YEL: begin
            pr = s2_chroma_ff; pg = s2_x_ff;
         end
         SEC_YEL_GRN: begin
            pr = s2_x_ff; pg = s2_chroma_ff;
         end
         SEC_GRN_CYN: begin
            pg = s2_chroma_ff; pb = s2_x_ff;
         end
         SEC_CYN_BLU: begin
            pg = s2_x_ff; pb = s2_chroma_ff;
         end
         SEC_BLU_MAG: begin
            pr = s2_x_ff; pb = s2_chroma_ff;
         end
         default: begin
            pr = s2_chroma_ff; pb = s2_x_ff;
         end
      endcase

      if (s2_grey_ff) begin
         red_in   = s2_light_ff;
         green_in = s2_light_ff;
         blue_in  = s2_light_ff;
      end else begin
         red_in   = clamp_sum(pr, s2_m_ff);
         green_in = clamp_sum(pg, s2_m_ff);
         blue_in  = clamp_sum(pb, s2_m_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= in_valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && in_valid) begin
         s1_grey_ff   <= in_item.grey;
         s1_sector_ff <= in_item.sector;
         s1_weight_ff <= in_item.weight;
         s1_light_ff  <= in_item.lightness;
         s1_chroma_ff <= chroma_prod[2*CH_W-1:CH_W];
      end
      if (adv2 && s1_valid_ff) begin
         s2_grey_ff   <= s1_grey_ff;
         s2_sector_ff <= s1_sector_ff;
         s2_light_ff  <= s1_light_ff;
         s2_chroma_ff <= s1_chroma_ff;
         s2_x_ff      <= x_prod[2*CH_W-1:CH_W];
         s2_m_ff      <= m_in;
      end
      if (adv3 && s2_valid_ff) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   // The secondary component never exceeds the chroma it is scaled from.
   a_x_le_c: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_x_ff <= s2_chroma_ff))
      else $error("secondary component above chroma");

   // A stalled middle stage keeps its item.
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv3) |=> (s2_valid_ff && $stable(s2_x_ff) && $stable(s2_m_ff)))
      else $error("middle stage lost an item under stall");

endmodule

// ----- hdl/hsl_to_rgb_converter.sv -----
// Top level of the HSL to RGB pixel converter.
//
//   channel   dir   handshake             payload
//   req_      in    req_tvalid/tready     tdata: hue, saturation, lightness
//   rsp_      out   rsp_tvalid/tready     tdata: red_out, green_out, blue_out
//
// One pixel is accepted per clock while the pipeline is not backed up by a stalled rsp_ side.
// The front register, a four-entry queue and three arithmetic stages all run at one item
// per cycle unless the rsp_ side stalls, limited by the two 17x16 multipliers, each in a stage of its own.
// A stalled rsp_ side fills the back stages and then the queue before req_tready drops.
// Reset (synchronous, active high) empties the front register, queue and all stages.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [3*CH_W-1:0] req_tdata,   // hue [15:0], saturation [31:16], lightness [47:32]
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [3*CH_W-1:0] rsp_tdata    // red_out [15:0], green_out [31:16], blue_out [47:32]
);

   logic      fe_valid;
   logic      fe_ready;
   class_type fe_item;
   logic      q_valid;
   logic      q_ready;
   class_type q_item;
   logic [CH_W-1:0] red_out;
   logic [CH_W-1:0] green_out;
   logic [CH_W-1:0] blue_out;

   hsl2rgb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .hue        (req_tdata[CH_W-1:0]),
      .saturation (req_tdata[2*CH_W-1:CH_W]),
      .lightness  (req_tdata[3*CH_W-1:2*CH_W]),
      .out_valid  (fe_valid),
      .out_ready  (fe_ready),
      .out_item   (fe_item)
   );

   hsl2rgb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   hsl2rgb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .red_out   (red_out),
      .green_out (green_out),
      .blue_out  (blue_out)
   );

   assign rsp_tdata = {blue_out, green_out, red_out};

endmodule

// ----- verif/hsl_to_rgb_converter_test.sv -----
// Self-checking testbench for the HSL to RGB pixel converter.
`timescale 1ns / 100ps

module hsl_to_rgb_converter_test import hsl2rgb_pkg::*; ();

   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 880;
   localparam int BURST_ITEMS  = 100;

   // Packed so that the last field sits in the lowest bits, as on the bus.
   typedef struct packed {
      logic [CH_W-1:0] lightness;
      logic [CH_W-1:0] saturation;
      logic [CH_W-1:0] hue;
   } hsl_pixel_type;

   typedef struct packed {
      logic [CH_W-1:0] blue_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] red_out;
   } rgb_pixel_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [3*CH_W-1:0] req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [3*CH_W-1:0] rsp_tdata;

   rgb_pixel_type expected_rgb[$];
   int         error_count   = 0;
   int         sent_count    = 0;
   int         checked_count = 0;
   int         cycle_count   = 0;
   int         ready_hold    = 0;
   bit         steady_flow   = 1'b0;

   hsl_to_rgb_converter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [CH_W-1:0] clamp_q16(int value);
      if (value < 0) return '0;
      if (value > 65535) return '1;
      return value[CH_W-1:0];
   endfunction

   // Fixed-point HSL to RGB conversion: every product is floored back to Q0.16.
   function automatic rgb_pixel_type convert_pixel(hsl_pixel_type px);
      logic [WIDE_W-1:0] two_l;
      logic [WIDE_W-1:0] dist_l;
      logic [WIDE_W-1:0] span;
      logic [WIDE_W-1:0] frac2;
      logic [WIDE_W-1:0] dist_h;
      logic [WIDE_W-1:0] weight;
      logic [18:0]       h6;
      logic [32:0]       product;
      logic [CH_W-1:0]   chroma;
      logic [CH_W-1:0]   second;
      logic [CH_W-1:0]   r1;
      logic [CH_W-1:0]   g1;
      logic [CH_W-1:0]   b1;
      sector_type        sector;
      int                offset;
      rgb_pixel_type     rgb;
      if (px.saturation == '0) begin
         rgb.red_out   = px.lightness;
         rgb.green_out = px.lightness;
         rgb.blue_out  = px.lightness;
         return rgb;
      end
      two_l   = {px.lightness, 1'b0};
      dist_l  = (two_l >= ONE_Q16) ? two_l - ONE_Q16 : ONE_Q16 - two_l;
      span    = ONE_Q16 - dist_l;
      product = 33'(span) * 33'(px.saturation);
      chroma  = product[31:16];
      h6      = 19'(px.hue) * 19'd6;
      sector  = sector_type'(h6[18:16]);
      frac2   = h6[16:0];
      dist_h  = (frac2 >= ONE_Q16) ? frac2 - ONE_Q16 : ONE_Q16 - frac2;
      weight  = ONE_Q16 - dist_h;
      product = 33'(chroma) * 33'(weight);
      second  = product[31:16];
      offset  = int'(px.lightness) - int'(chroma >> 1);
      case (sector)
         SEC_RED_YEL: begin r1 = chroma; g1 = second; b1 = '0;     end
         SEC_YEL_GRN: begin r1 = second; g1 = chroma; b1 = '0;     end
         SEC_GRN_CYN: begin r1 = '0;     g1 = chroma; b1 = second; end
         SEC_CYN_BLU: begin r1 = '0;     g1 = second; b1 = chroma; end
         SEC_BLU_MAG: begin r1 = second; g1 = '0;     b1 = chroma; end
         default: begin     r1 = chroma; g1 = '0;     b1 = second; end
      endcase
      rgb.red_out   = clamp_q16(int'(r1) + offset);
      rgb.green_out = clamp_q16(int'(g1) + offset);
      rgb.blue_out  = clamp_q16(int'(b1) + offset);
      return rgb;
   endfunction

   task automatic check_channel(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Predict on every accepted item and compare every accepted result.
   always @(posedge clock) begin
      rgb_pixel_type want;
      rgb_pixel_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_rgb.push_back(convert_pixel(hsl_pixel_type'(req_tdata)));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rgb_pixel_type'(rsp_tdata);
            if (expected_rgb.size() == 0) begin
               $error("result with no item outstanding: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_rgb.pop_front();
               check_channel("red_out", want.red_out, got.red_out);
               check_channel("green_out", want.green_out, got.green_out);
               check_channel("blue_out", want.blue_out, got.blue_out);
               checked_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("hsl_to_rgb_converter_test: done, errors");
         $finish;
      end
   end

   // Result-side back-pressure: mostly ready, short stalls, now and then a long one.
   always @(negedge clock) begin
      int roll;
      if (steady_flow) begin
         rsp_tready <= 1'b1;
         ready_hold = 0;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            rsp_tready <= 1'b1;
            ready_hold = $urandom_range(0, 20);
         end else if (roll < 90) begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(0, 2);
         end else begin
            rsp_tready <= 1'b0;
            ready_hold = $urandom_range(8, 40);
         end
      end
   end

   // Called and returns at a falling edge; req_tvalid is left high, and the next call lowers it only for a gap.
   task automatic send_pixel(logic [CH_W-1:0] hue, logic [CH_W-1:0] sat,
                             logic [CH_W-1:0] light);
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (steady_flow || roll < 50) gap = 0;
      else if (roll < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {light, sat, hue};
      do @(posedge clock); while (!req_tready);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic test_grey_pixels();
      send_pixel(16'd0, 16'd0, 16'd0);
      send_pixel(16'hFFFF, 16'd0, 16'hFFFF);
      send_pixel(16'h5A5A, 16'd0, 16'd32768);
   endtask

   task automatic test_field_extremes();
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(16'd0, 16'hFFFF, 16'd32768);
      send_pixel(16'hFFFF, 16'hFFFF, 16'd32767);
      send_pixel(16'd0, 16'hFFFF, 16'd0);
      send_pixel(16'hFFFF, 16'd1, 16'd1);
   endtask

   // Hues at the first code of each sixth of the wheel and, from the second sixth on, just below it.
   task automatic test_sector_boundaries();
      logic [CH_W-1:0] starts[6];
      starts = '{16'd0, 16'd10923, 16'd21846, 16'd32768, 16'd43691, 16'd54614};
      foreach (starts[k]) begin
         send_pixel(starts[k], 16'hFFFF, 16'd32768);
         if (k > 0) send_pixel(starts[k] - 16'd1, 16'hFFFF, 16'd32768);
      end
   endtask

   // Bright pixels whose channel sum runs past full scale.
   task automatic test_top_saturation();
      send_pixel(16'd5000, 16'hFFFF, 16'd49152);
      send_pixel(16'd30000, 16'd32768, 16'hFFFF);
   endtask

   task automatic test_back_to_back();
      steady_flow = 1'b1;
      repeat (BURST_ITEMS) send_pixel(16'($urandom), 16'($urandom), 16'($urandom));
      steady_flow = 1'b0;
   endtask

   task automatic test_random_pixels();
      int roll;
      logic [CH_W-1:0] sat;
      logic [CH_W-1:0] light;
      repeat (RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) sat = '0;
         else if (roll < 20) sat = '1;
         else sat = 16'($urandom);
         roll = $urandom_range(0, 99);
         case (roll % 4)
            0: light = '0;
            1: light = '1;
            2: light = 16'd32768;
            default: light = 16'd32767;
         endcase
         if (roll >= 12) light = 16'($urandom);
         send_pixel(16'($urandom), sat, light);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_grey_pixels();
      test_field_extremes();
      test_sector_boundaries();
      test_top_saturation();
      test_back_to_back();
      test_random_pixels();
      req_tvalid <= 1'b0;

      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d pixels: grey, extremes, sector edges, saturation, burst, random.",
               sent_count);
      $display("Checked %0d RGB results under random gaps and back-pressure.", checked_count);
      if (error_count == 0 && expected_rgb.size() == 0) begin
         $display("hsl_to_rgb_converter_test: done, clean");
      end else begin
         $display("hsl_to_rgb_converter_test: done, errors");
      end
      $finish;
   end

endmodule
